@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: request kinds, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEFAULT    = 64;
  localparam int KEY_BITS_DEFAULT = 32;
  localparam int KEY_PORT_BITS    = 32;
  localparam int POSITION_BITS    = 6;
  localparam int FILL_BITS        = 7;

  // request kinds; the unused code behaves as a search
  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_ABSENT  = 2'd1;
  localparam logic [1:0] STATUS_PRESENT = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_WRITE_KEY,
    ST_SHIFT_DN,
    ST_FINISH
  } skt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture request, reset search bounds
    logic probe_rd;     // read entry at midpoint
    logic probe_upd;    // compare and narrow bounds
    logic init_up;      // set up shift toward higher indexes
    logic init_dn;      // set up shift toward lower indexes
    logic shift_up_rd;  // read one entry for an up shift
    logic shift_dn_rd;  // read one entry for a down shift
    logic write_key;    // store new key at lower bound, count up
    logic dec_count;    // count down after delete
    logic report;       // register result
  } skt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       lo_lt_hi;
    logic       ptr_gt_lo;
    logic       ptr_lt_cnt;
    logic       found;
    logic       full;
  } skt_status_t;

endpackage

@@ rtl/core/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: binary search probes, then an optional shift pass and result.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  skt_status_t stat,
  output skt_cmd_t    cmd,
  output logic        busy
);

  skt_state_t state;
  skt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.probe_rd = 1'b1;
          state_next   = ST_PROBE_CMP;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_PROBE_CMP: begin
        cmd.probe_upd = 1'b1;
        state_next    = ST_PROBE_RD;
      end
      ST_DECIDE: begin
        state_next = ST_FINISH;
        case (stat.kind)
          KIND_INSERT: begin
            if (!stat.found && !stat.full) begin
              cmd.init_up = 1'b1;
              state_next  = ST_SHIFT_UP;
            end
          end
          KIND_DELETE: begin
            if (stat.found) begin
              cmd.init_dn = 1'b1;
              state_next  = ST_SHIFT_DN;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SHIFT_UP: begin
        if (stat.ptr_gt_lo) begin
          cmd.shift_up_rd = 1'b1;
        end else begin
          state_next = ST_WRITE_KEY;  // last pending move drains this cycle
        end
      end
      ST_WRITE_KEY: begin
        cmd.write_key = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_SHIFT_DN: begin
        if (stat.ptr_lt_cnt) begin
          cmd.shift_dn_rd = 1'b1;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/skt_datapath.sv @@
// ----------------------------------------------------------------------------
// skt_datapath
// Key memory, search bounds, shift pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module skt_datapath import skt_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int KEY_BITS    = KEY_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               kind,
  input  logic [KEY_PORT_BITS-1:0] key,
  input  logic                     cfg_valid,
  input  logic                     cfg_signed_order,
  input  skt_cmd_t                 cmd,
  output skt_status_t              stat,
  output logic                     done,
  output logic                     hit,
  output logic [POSITION_BITS-1:0] position,
  output logic [1:0]               status,
  output logic [FILL_BITS-1:0]     fill_count
);

  localparam int IDXW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW  = $clog2(TABLE_DEPTH + 1);
  localparam int KW_IN = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;

  logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rd_data;
  logic [KEY_BITS-1:0] key_reg;
  logic [1:0]          kind_reg;
  logic                signed_order;
  logic [CNTW-1:0]     count;
  logic [CNTW-1:0]     lo;
  logic [CNTW-1:0]     hi;
  logic [CNTW-1:0]     ptr;
  logic [IDXW-1:0]     wr_addr;
  logic                pend;
  logic                eq_flag;
  logic                inserted;

  logic [CNTW:0]       mid_sum;
  logic [CNTW-1:0]     mid;
  logic [KEY_BITS-1:0] flip;
  logic                less;
  logic                found;
  logic                full;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNTW:1];
  // signed order: flipping the sign bit turns it into an unsigned compare
  assign flip    = {signed_order, {(KEY_BITS-1){1'b0}}};
  assign less    = (rd_data ^ flip) < (key_reg ^ flip);
  assign found   = eq_flag;  // only set when hi moved onto a matching entry
  assign full    = (count >= CNTW'(TABLE_DEPTH));

  always_comb begin
    stat            = '0;
    stat.kind       = kind_reg;
    stat.lo_lt_hi   = lo < hi;
    stat.ptr_gt_lo  = ptr > lo;
    stat.ptr_lt_cnt = ptr < count;
    stat.found      = found;
    stat.full       = full;
  end

  // key memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      rd_data <= mem[mid[IDXW-1:0]];
    end else if (cmd.shift_up_rd) begin
      rd_data <= mem[IDXW'(ptr - CNTW'(1))];
    end else if (cmd.shift_dn_rd) begin
      rd_data <= mem[ptr[IDXW-1:0]];
    end
    if (pend) begin
      mem[wr_addr] <= rd_data;
    end else if (cmd.write_key) begin
      mem[lo[IDXW-1:0]] <= key_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg  <= KEY_BITS'(key[KW_IN-1:0]);
      kind_reg <= kind;
    end
    if (cmd.load) begin
      inserted <= 1'b0;
    end else if (cmd.write_key) begin
      inserted <= 1'b1;
    end
    if (cmd.load) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.probe_upd) begin
      if (less) begin
        lo <= mid + CNTW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.init_up) begin
      ptr <= count;
    end else if (cmd.init_dn) begin
      ptr <= lo + CNTW'(1);
    end else if (cmd.shift_up_rd) begin
      ptr     <= ptr - CNTW'(1);
      wr_addr <= ptr[IDXW-1:0];
    end else if (cmd.shift_dn_rd) begin
      ptr     <= ptr + CNTW'(1);
      wr_addr <= IDXW'(ptr - CNTW'(1));
    end
    if (cmd.report) begin
      hit        <= found;
      fill_count <= FILL_BITS'(count);
      position   <= '0;
      status     <= found ? STATUS_DONE : STATUS_ABSENT;
      if (found) begin
        position <= POSITION_BITS'(lo);
      end
      if (kind_reg == KIND_INSERT) begin
        if (found) begin
          status <= STATUS_PRESENT;
        end else if (!inserted) begin
          // no slot was opened: the table was full at the request
          status <= STATUS_FULL;
        end else begin
          status   <= STATUS_DONE;
          position <= POSITION_BITS'(lo);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      signed_order <= 1'b0;
      done         <= 1'b0;
      pend         <= 1'b0;
      eq_flag      <= 1'b0;
    end else begin
      done <= cmd.report;
      pend <= cmd.shift_up_rd | cmd.shift_dn_rd;
      if (cfg_valid) begin
        signed_order <= cfg_signed_order;
      end
      if (cmd.write_key) begin
        count <= count + CNTW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNTW'(1);
      end
      if (cmd.load) begin
        eq_flag <= 1'b0;
      end else if (cmd.probe_upd && !less) begin
        eq_flag <= (rd_data == key_reg);
      end
    end
  end

endmodule

@@ rtl/core/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table
// Ascending key table with binary search, insert and delete.
// ----------------------------------------------------------------------------
// Pulse start with kind and key while busy is low; the request is taken at
// that edge and busy rises. One result follows per request, shown for exactly
// one cycle with done high: hit, position, status and the fill count after
// the operation. The receiver cannot stall it, so capture it when done is
// seen. Each search probe is a memory read, then a compare; an insert or
// delete that moves entries moves them one at a time through the single read
// and single write port of the key memory. A new request may be started in
// the same cycle that done is shown. The ordering mode (cfg_signed_order) is
// taken whenever cfg_valid is high and should be changed only while idle;
// stored keys are not reordered when it changes. No clearing pass runs after
// reset: entries are only read below the fill count.
// ----------------------------------------------------------------------------
module sorted_key_table import skt_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int KEY_BITS    = KEY_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic [KEY_PORT_BITS-1:0] key,
  // result channel, one-cycle strobe
  output logic                     done,
  output logic                     hit,
  output logic [POSITION_BITS-1:0] position,
  output logic [1:0]               status,
  output logic [FILL_BITS-1:0]     fill_count,
  // ordering mode register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_signed_order
);

  skt_cmd_t    cmd;
  skt_status_t stat;

  // register transfer always accepted
  assign cfg_ready = 1'b1;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  skt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .kind             (kind),
    .key              (key),
    .cfg_valid        (cfg_valid),
    .cfg_signed_order (cfg_signed_order),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .hit              (hit),
    .position         (position),
    .status           (status),
    .fill_count       (fill_count)
  );

endmodule

@@ rtl/core/skt_checker.sv @@
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks of request/result sequencing and result consistency.
// ----------------------------------------------------------------------------
module skt_checker import skt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic                     hit,
  input logic [POSITION_BITS-1:0] position,
  input logic [1:0]               status
);

  // a result only follows a request in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without request in flight");

  // the result strobe is never high back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a taken request makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  // full or absent results carry no hit and no position
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL || status == STATUS_ABSENT))
      |-> (!hit && position == '0))
    else $error("miss result with hit or position set");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit      (hit),
  .position (position),
  .status   (status)
);

@@ test/sorted_key_table_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A short directed table covers
// the key extremes, each request kind and a change of ordering while keys are
// stored. Random phases of churn, fill, drain and mixed-order traffic follow.
// Every result is checked against a written outcome or an in-bench table model.
// ----------------------------------------------------------------------------
module sorted_key_table_tb import skt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = DEPTH_DEFAULT;
  localparam int          TOTAL_ITEMS  = 1100;
  localparam int          QUIET_FROM   = 950;      // no sender idling in phases started past here
  localparam int          SETTLE       = 200;      // > worst request latency
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          REPORT_LIMIT = 200;      // cap on mismatch lines
  localparam int          POOL_SIZE    = 16;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;     // decoded as a search
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

  typedef struct packed {
    logic                     hit;
    logic [POSITION_BITS-1:0] position;
    logic [1:0]               status;
    logic [FILL_BITS-1:0]     fill;
  } outcome_t;

  typedef struct packed {
    logic        is_cfg;   // ordering write, value in key[0]
    logic [1:0]  op;
    logic [31:0] key;
    logic        typed;    // use the written outcome instead of the model
    outcome_t    want;
  } directed_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               kind = KIND_SEARCH;
  logic [KEY_PORT_BITS-1:0] key = '0;
  logic                     done;
  logic                     hit;
  logic [POSITION_BITS-1:0] position;
  logic [1:0]               status;
  logic [FILL_BITS-1:0]     fill_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_signed_order = 1'b0;

  always #5 clk = ~clk;

  sorted_key_table u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .key              (key),
    .done             (done),
    .hit              (hit),
    .position         (position),
    .status           (status),
    .fill_count       (fill_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_signed_order (cfg_signed_order)
  );

  // --------------------------------------------------------------------------
  // Table model: a mirror of the stored keys, the fill count and the ordering
  // bit. Updated at the edge where a request transfer happens, so it always
  // reflects the state the block will see when it works on the next request.
  // --------------------------------------------------------------------------
  logic [31:0] tbl_keys [DEPTH];
  int unsigned tbl_count  = 0;
  logic        tbl_signed = 1'b0;

  outcome_t    expected_outcomes [$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned cycles_run  = 0;
  logic        sender_idles = 1'b1;
  logic [31:0] key_pool [POOL_SIZE];

  // Flipping the sign bit turns two's complement order into plain unsigned
  // order, so one compare serves both modes.
  function automatic logic [31:0] order_value(logic [31:0] k);
    return tbl_signed ? (k ^ SIGN_BIT) : k;
  endfunction

  // Lower bound over the stored keys. Has to follow the same halving as the
  // hardware: once the ordering changes under stored keys the answer depends
  // on which entries get probed.
  function automatic int unsigned find_slot(logic [31:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (order_value(tbl_keys[mid]) < order_value(k)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic key_present(logic [31:0] k);
    int unsigned slot;
    slot = find_slot(k);
    return slot < tbl_count && tbl_keys[slot] == k;
  endfunction

  // Applies one request to the mirror and returns what the block must report.
  function automatic outcome_t apply_request(logic [1:0] op, logic [31:0] k);
    outcome_t    r;
    int unsigned slot;
    logic        present;
    r       = '0;
    slot    = find_slot(k);
    present = slot < tbl_count && tbl_keys[slot] == k;
    case (op)
      KIND_INSERT: begin
        if (present) begin
          r.hit      = 1'b1;
          r.position = POSITION_BITS'(slot);
          r.status   = STATUS_PRESENT;
        end else if (tbl_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = tbl_count; i > slot; i--) tbl_keys[i] = tbl_keys[i-1];
          tbl_keys[slot] = k;
          tbl_count++;
          r.position = POSITION_BITS'(slot);
          r.status   = STATUS_DONE;
        end
      end
      KIND_DELETE: begin
        if (present) begin
          for (int i = slot; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
          tbl_count--;
          r.hit      = 1'b1;
          r.position = POSITION_BITS'(slot);
          r.status   = STATUS_DONE;
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
      default: begin
        // search, and the unused kind behaves the same
        if (present) begin
          r.hit      = 1'b1;
          r.position = POSITION_BITS'(slot);
          r.status   = STATUS_DONE;
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
    endcase
    r.fill = FILL_BITS'(tbl_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Key choice: stored keys for hits, a small per-phase pool for repeats and
  // near-misses, and fully random words for the rest.
  // --------------------------------------------------------------------------
  function automatic void refresh_pool();
    foreach (key_pool[i]) begin
      case ($urandom_range(0, 5))
        0: key_pool[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : SIGN_BIT;
        1: key_pool[i] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        2: key_pool[i] = SIGN_BIT + 32'($urandom_range(0, 15)) - 32'd8;
        3: key_pool[i] = 32'($urandom_range(0, 15)) - 32'd8;
        default: key_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && tbl_count != 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    if (roll < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. start is driven at the clock edge; the transfer happens at
  // the first later edge with busy low. start stays high between back-to-back
  // requests so it never sees two updates in one step.
  // --------------------------------------------------------------------------
  task automatic issue(input logic [1:0] op, input logic [31:0] k,
                       input logic use_typed = 1'b0, input outcome_t typed_want = '0);
    outcome_t predicted;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // sometimes let the block go idle first so the gap is actually seen
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= op;
    key   <= k;
    do @(posedge clk); while (busy);
    predicted = apply_request(op, k);
    expected_outcomes.push_back(use_typed ? typed_want : predicted);
    items_sent++;
  endtask

  // Hold off until every outstanding result has come back and the block is
  // idle. It always waits on a clock edge, so start is never updated twice in
  // one step by this and the following transfer.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0 || busy);
  endtask

  // Ordering register write; only called with the block quiet.
  task automatic write_order(input logic value);
    repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_signed_order <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    tbl_signed  = value;
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------

  // Mixed traffic around the current fill level.
  task automatic churn_phase();
    int unsigned len, roll;
    logic [1:0]  op;
    len = $urandom_range(40, 90);
    repeat (len) begin
      roll = $urandom_range(0, 19);
      if (roll < 8)       op = KIND_INSERT;
      else if (roll < 13) op = KIND_SEARCH;
      else if (roll < 19) op = KIND_DELETE;
      else                op = KIND_UNUSED;
      issue(op, pick_key());
      if ($urandom_range(0, 29) == 0) wait_quiet();
    end
  endtask

  // Insert until full, push a few more at the full table, then look around.
  task automatic fill_phase();
    int unsigned guard;
    guard = 0;
    while (tbl_count < DEPTH && guard < 200) begin
      issue(KIND_INSERT, $urandom_range(0, 9) < 7 ? 32'($urandom) : pick_key());
      guard++;
    end
    repeat ($urandom_range(3, 6)) issue(KIND_INSERT, pick_key());
    repeat ($urandom_range(5, 12)) issue(KIND_SEARCH, pick_key());
  endtask

  // Delete stored keys down to empty, then poke the empty table.
  task automatic drain_phase();
    int unsigned guard;
    guard = 0;
    while (tbl_count != 0 && guard < 200) begin
      if ($urandom_range(0, 4) == 0) issue(KIND_SEARCH, pick_key());
      issue(KIND_DELETE, tbl_keys[$urandom_range(0, tbl_count - 1)]);
      guard++;
    end
    issue(KIND_DELETE, pick_key());
    issue(KIND_SEARCH, pick_key());
    issue(KIND_DELETE, $urandom);
  endtask

  // Flip the ordering with keys stored. Only requests that keep the stored
  // keys sorted in the original order are sent: searches, deletes, inserts
  // that hit or meet a full table. Then the ordering goes back.
  task automatic mixed_order_phase();
    logic        home;
    logic [31:0] k;
    int unsigned len;
    home = tbl_signed;
    wait_quiet();
    write_order(!home);
    len = $urandom_range(15, 30);
    repeat (len) begin
      k = pick_key();
      case ($urandom_range(0, 2))
        0: issue(KIND_SEARCH, k);
        1: issue(KIND_DELETE, tbl_count != 0 ? tbl_keys[$urandom_range(0, tbl_count - 1)] : k);
        default: begin
          if (key_present(k) || tbl_count >= DEPTH) issue(KIND_INSERT, k);
          else issue(KIND_UNUSED, k);
        end
      endcase
    end
    wait_quiet();
    write_order(home);
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Written outcomes where they follow at a glance; the rest
  // go through the model. The ordering flip near the end leaves five keys
  // stored in unsigned order and searches them under signed compare.
  // --------------------------------------------------------------------------
  directed_row_t directed_rows [23] = '{
    // empty table after reset
    '{1'b0, KIND_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, STATUS_ABSENT,  7'd0}},
    '{1'b0, KIND_DELETE, 32'h0000_0005, 1'b1, '{1'b0, 6'd0, STATUS_ABSENT,  7'd0}},
    '{1'b0, KIND_UNUSED, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, STATUS_ABSENT,  7'd0}},
    // extremes, duplicate insert, insert in the middle
    '{1'b0, KIND_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, STATUS_DONE,    7'd1}},
    '{1'b0, KIND_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd1, STATUS_DONE,    7'd2}},
    '{1'b0, KIND_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 6'd0, STATUS_PRESENT, 7'd2}},
    '{1'b0, KIND_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 6'd1, STATUS_DONE,    7'd3}},
    '{1'b0, KIND_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 6'd1, STATUS_DONE,    7'd4}},
    // hits and a miss, unused kind as a search
    '{1'b0, KIND_SEARCH, 32'h8000_0000, 1'b1, '{1'b1, 6'd2, STATUS_DONE,    7'd4}},
    '{1'b0, KIND_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd3, STATUS_DONE,    7'd4}},
    '{1'b0, KIND_SEARCH, 32'h1234_5678, 1'b1, '{1'b0, 6'd0, STATUS_ABSENT,  7'd4}},
    '{1'b0, KIND_UNUSED, 32'h7FFF_FFFF, 1'b1, '{1'b1, 6'd1, STATUS_DONE,    7'd4}},
    // delete, then delete of the same key again
    '{1'b0, KIND_DELETE, 32'h7FFF_FFFF, 1'b1, '{1'b1, 6'd1, STATUS_DONE,    7'd3}},
    '{1'b0, KIND_DELETE, 32'h7FFF_FFFF, 1'b1, '{1'b0, 6'd0, STATUS_ABSENT,  7'd3}},
    '{1'b0, KIND_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
    '{1'b0, KIND_INSERT, 32'h5555_5555, 1'b0, '0},
    // signed compare over keys stored in unsigned order
    '{1'b1, KIND_SEARCH, 32'h0000_0001, 1'b0, '0},
    '{1'b0, KIND_SEARCH, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, KIND_SEARCH, 32'h8000_0000, 1'b0, '0},
    '{1'b0, KIND_SEARCH, 32'h0000_0000, 1'b0, '0},
    '{1'b0, KIND_DELETE, 32'hAAAA_AAAA, 1'b0, '0},
    '{1'b1, KIND_SEARCH, 32'h0000_0000, 1'b0, '0},
    '{1'b0, KIND_SEARCH, 32'h5555_5555, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned roll;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_quiet();
        write_order(directed_rows[i].key[0]);
      end else begin
        issue(directed_rows[i].op, directed_rows[i].key,
              directed_rows[i].typed, directed_rows[i].want);
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      // every phase starts from a quiet block with a register write; the
      // ordering may only move freely while the table is empty
      wait_quiet();
      write_order(tbl_count == 0 ? logic'($urandom_range(0, 1)) : tbl_signed);
      refresh_pool();
      sender_idles = items_sent < QUIET_FROM && $urandom_range(0, 3) != 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        churn_phase();
      end else if (roll < 65) begin
        fill_phase();
      end else if (roll < 85) begin
        drain_phase();
        wait_quiet();
        write_order(!tbl_signed);
      end else if (tbl_count != 0) begin
        mixed_order_phase();
      end else begin
        churn_phase();
      end
    end

    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. done is sampled at the edge that ends its cycle; each result
  // transfer pops the oldest expected outcome.
  // --------------------------------------------------------------------------
  outcome_t oldest;

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: result with nothing expected, actual hit=%0h pos=%0h st=%0h fill=%0h",
                   $time, hit, position, status, fill_count);
      end else begin
        oldest = expected_outcomes.pop_front();
        check_field("hit",        oldest.hit,      hit);
        check_field("position",   oldest.position, position);
        check_field("status",     oldest.status,   status);
        check_field("fill_count", oldest.fill,     fill_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

@@ sorted_key_table.f @@
rtl/core/skt_pkg.sv
rtl/core/skt_ctrl.sv
rtl/core/skt_datapath.sv
rtl/core/sorted_key_table.sv
rtl/core/skt_checker.sv
test/sorted_key_table_tb.sv
